@@ hdl/fcp_pkg.sv @@
package fcp_pkg;

  // frame layout
  localparam int FCP_BUFFER_DEPTH = 32;
  localparam int CMD_COUNT        = 40;
  localparam int CODE_W           = 6;
  localparam int ARG_W            = 16;
  localparam int OUT_TDATA_W      = 24;

  // framing characters
  localparam logic [7:0] FRAME_END   = 8'h23;
  localparam logic [7:0] FRAME_START = 8'h3A;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_X_UP     = 8'h58;
  localparam logic [7:0] CH_X_LO     = 8'h78;
  localparam logic [7:0] CH_SPACE    = 8'h20;

  // command table, first char in the high byte, zero low byte means one-char command
  localparam logic [15:0] CMD_TBL [CMD_COUNT] = '{
    16'h5858, 16'h4750, 16'h4749, 16'h4647, 16'h4651, 16'h5048, 16'h474E, 16'h5346,
    16'h5348, 16'h4748, 16'h4753, 16'h5353, 16'h5350, 16'h534E, 16'h4754, 16'h475A,
    16'h4756, 16'h4746, 16'h4744, 16'h5344, 16'h5343, 16'h4743, 16'h504F, 16'h534D,
    16'h474D, 16'h5359, 16'h4759, 16'h474F, 16'h534F, 16'h4752, 16'h5352, 16'h4D53,
    16'h4742, 16'h4453, 16'h4447, 16'h5355, 16'h2B00, 16'h2D00, 16'h4444, 16'h4D52
  };

  // top level sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } fcp_state_t;

  // argument parser phases
  typedef enum logic [2:0] {
    P_LEAD,
    P_SIGN,
    P_DIGIT,
    P_XWAIT,
    P_STOP
  } fcp_phase_t;

  // control from sequencer to the argument unit
  typedef struct packed {
    logic clear;
    logic step;
  } fcp_arg_ctrl_t;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) r = c - 8'h20;
    return r;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    v = '0;
    if (c >= 8'h30 && c <= 8'h39) v = c[3:0];
    else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) v = c[3:0] + 4'd9;
    return v;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // case-insensitive table match, last hit wins
  function automatic logic [CODE_W-1:0] match_cmd(input logic [7:0] c0,
                                                  input logic [7:0] c1,
                                                  input logic       two);
    logic [CODE_W-1:0] code;
    logic              tlen2;
    code = '0;
    for (int i = 0; i < CMD_COUNT; i++) begin
      tlen2 = (CMD_TBL[i][7:0] != 8'h00);
      if (tlen2 == two && upcase(c0) == CMD_TBL[i][15:8] &&
          (!two || upcase(c1) == CMD_TBL[i][7:0])) begin
        code = CODE_W'(i);
      end
    end
    return code;
  endfunction

endpackage

@@ hdl/fcp_frame_mem.sv @@
module fcp_frame_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hdl/fcp_arg_unit.sv @@
module fcp_arg_unit
  import fcp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  fcp_arg_ctrl_t       ctrl,
  input  logic [7:0]          ch,
  output logic [ARG_W-1:0]    value
);

  fcp_phase_t       phase, phase_next;
  logic [ARG_W-1:0] acc, acc_next;
  logic             neg, neg_next;
  logic             first_zero, first_zero_next;

  // phase register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_LEAD;
    end else begin
      phase <= phase_next;
    end
  end

  // accumulator and flags
  always_ff @(posedge clk) begin
    acc        <= acc_next;
    neg        <= neg_next;
    first_zero <= first_zero_next;
  end

  // one character per step
  always_comb begin
    phase_next      = phase;
    acc_next        = acc;
    neg_next        = neg;
    first_zero_next = first_zero;
    if (ctrl.clear) begin
      phase_next      = P_LEAD;
      acc_next        = '0;
      neg_next        = 1'b0;
      first_zero_next = 1'b0;
    end else if (ctrl.step) begin
      case (phase)
        P_LEAD: begin
          if (is_space(ch)) begin
            phase_next = P_LEAD;
          end else if (ch == CH_PLUS || ch == CH_MINUS) begin
            neg_next   = (ch == CH_MINUS);
            phase_next = P_SIGN;
          end else if (is_hex(ch)) begin
            acc_next        = ARG_W'(hex_val(ch));
            first_zero_next = (ch == CH_ZERO);
            phase_next      = P_DIGIT;
          end else begin
            phase_next = P_STOP;
          end
        end
        P_SIGN: begin
          // first digit right after the sign, may open a 0x prefix
          if (is_hex(ch)) begin
            acc_next        = ARG_W'(hex_val(ch));
            first_zero_next = (ch == CH_ZERO);
            phase_next      = P_DIGIT;
          end else begin
            phase_next = P_STOP;
          end
        end
        P_DIGIT: begin
          if (is_hex(ch)) begin
            acc_next        = {acc[ARG_W-5:0], hex_val(ch)};
            first_zero_next = 1'b0;
          end else if (first_zero && (ch == CH_X_UP || ch == CH_X_LO)) begin
            first_zero_next = 1'b0;
            phase_next      = P_XWAIT;
          end else begin
            phase_next = P_STOP;
          end
        end
        P_XWAIT: begin
          // prefix counts only when a digit follows; acc is zero either way
          if (is_hex(ch)) begin
            acc_next   = ARG_W'(hex_val(ch));
            phase_next = P_DIGIT;
          end else begin
            phase_next = P_STOP;
          end
        end
        P_STOP: begin
          phase_next = P_STOP;
        end
        default: begin
          phase_next = P_STOP;
        end
      endcase
    end
  end

  assign value = neg ? (ARG_W'(0) - acc) : acc;

endmodule

@@ hdl/focuser_command_frame_parser_core.sv @@
// channel   dir  width  fields (lowest bit up)
// s_axis    in   8      rx_byte[7:0]
// m_axis    out  24     command_code[5:0], has_argument[6], argument[22:7], zero[23]
//
// a byte other than '#' or ':' is written into the frame memory; ':' restarts the index
// after a '#' is taken the input stays blocked while the frame is walked and the
// result is stored (len = frame length, at most BUFFER_DEPTH-1): the frame memory is read one
// character per cycle through its single read port and each character after the
// first two goes through the shared argument step unit
// rst is synchronous, active high; it clears the index, sequencer and output valid
// a waiting result on m_axis does not block bytes; after the next '#' the
// sequencer waits in its done state until the output register is free
module focuser_command_frame_parser_core
  import fcp_pkg::*;
#(
  parameter int BUFFER_DEPTH = FCP_BUFFER_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // rx_byte[7:0]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // command_code[5:0], has_argument[6],
                                                 // argument[22:7], zero[23]
);

  localparam int IW = $clog2(BUFFER_DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(BUFFER_DEPTH - 1);

  fcp_state_t    state, state_next;
  logic [IW-1:0] widx, widx_next;
  logic [IW-1:0] len, len_next;
  logic [IW-1:0] rcnt, rcnt_next;
  logic [IW-1:0] didx, didx_next;
  logic          dv, dv_next;
  logic [7:0]    c0, c0_next;
  logic [7:0]    c1, c1_next;
  logic          out_valid, out_valid_next;
  logic [OUT_TDATA_W-1:0] out_data, out_data_next;

  logic          s_acc;
  logic          is_end;
  logic          is_start;
  logic          mem_we;
  logic [7:0]    rd_data;
  fcp_arg_ctrl_t arg_ctrl;
  logic [ARG_W-1:0] arg_value;
  logic [CODE_W-1:0] code;
  logic          has_arg;

  assign s_axis_tready = (state == S_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign is_end        = (s_axis_tdata == FRAME_END);
  assign is_start      = (s_axis_tdata == FRAME_START);
  assign mem_we        = s_acc && !is_end && !is_start;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // frame memory
  fcp_frame_mem #(
    .DEPTH (BUFFER_DEPTH),
    .AW    (IW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (widx),
    .wr_data (s_axis_tdata),
    .rd_addr (rcnt),
    .rd_data (rd_data)
  );

  // shared argument step unit
  assign arg_ctrl.clear = s_acc && is_end;
  assign arg_ctrl.step  = dv && (didx > IW'(1));

  fcp_arg_unit u_arg (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (arg_ctrl),
    .ch    (rd_data),
    .value (arg_value)
  );

  // command match and argument flag
  assign has_arg = (len > IW'(2));
  always_comb begin
    if (len == '0) begin
      code = '0;
    end else begin
      code = match_cmd(c0, c1, len >= IW'(2));
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      widx      <= '0;
      dv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      widx      <= widx_next;
      dv        <= dv_next;
      out_valid <= out_valid_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    len      <= len_next;
    rcnt     <= rcnt_next;
    didx     <= didx_next;
    c0       <= c0_next;
    c1       <= c1_next;
    out_data <= out_data_next;
  end

  // sequencer
  always_comb begin
    state_next     = state;
    widx_next      = widx;
    len_next       = len;
    rcnt_next      = rcnt;
    didx_next      = rcnt;
    dv_next        = 1'b0;
    c0_next        = c0;
    c1_next        = c1;
    out_valid_next = out_valid;
    out_data_next  = out_data;

    if (out_valid && m_axis_tready) out_valid_next = 1'b0;

    // keep the first two characters for the match
    if (dv && didx == IW'(0)) c0_next = rd_data;
    if (dv && didx == IW'(1)) c1_next = rd_data;

    case (state)
      S_IDLE: begin
        if (s_acc) begin
          if (is_end) begin
            len_next   = widx;
            rcnt_next  = '0;
            widx_next  = '0;
            state_next = S_WALK;
          end else if (is_start) begin
            widx_next = '0;
          end else if (widx != LAST_IDX) begin
            widx_next = widx + IW'(1);
          end
        end
      end
      S_WALK: begin
        if (rcnt != len) begin
          rcnt_next = rcnt + IW'(1);
          dv_next   = 1'b1;
        end else if (!dv) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || m_axis_tready) begin
          out_valid_next = 1'b1;
          out_data_next  = {1'b0, (has_arg ? arg_value : ARG_W'(0)), has_arg, code};
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // checks
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[5:0] <= CODE_W'(CMD_COUNT - 1)))
    else $error("command code out of table range");

  a_no_arg_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[6]) |-> (m_axis_tdata[22:7] == '0))
    else $error("argument nonzero without argument flag");

  a_end_busy: assert property (@(posedge clk) disable iff (rst)
    (s_acc && is_end) |=> !s_axis_tready)
    else $error("frame end did not start the walk");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (widx <= LAST_IDX))
    else $error("write index beyond buffer");

endmodule

@@ dv/focuser_command_frame_parser_core_tb.sv @@
`timescale 1ns / 100ps

module focuser_command_frame_parser_core_tb;
  import fcp_pkg::*;

  // one decoded frame as it leaves the block
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              has_arg;
    logic [ARG_W-1:0]  arg;
  } frame_result_t;

  localparam int MEM_DEPTH   = FCP_BUFFER_DEPTH;
  localparam int PHASE_ITEMS = 125;
  localparam int DRAIN_WAIT  = 60;

  // command names two characters each, a space marks a one-character command
  localparam logic [8*2*CMD_COUNT-1:0] CMD_NAMES = {
    "XXGPGIFGFQPHGNSF", "SHGHGSSSSPSNGTGZ", "GVGFGDSDSCGCPOSM",
    "GMSYGYGOSOGRSRMS", "GBDSDGSU+ - DDMR"
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata = '0;    // rx_byte[7:0]
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;         // command_code[5:0], has_argument[6],
                                                // argument[22:7], zero[23]

  logic [7:0]    pending_bytes [$];
  frame_result_t expected_frames [$];
  logic [7:0]    frame_mem [MEM_DEPTH];
  int unsigned   frame_len = 0;
  int unsigned   idle_pct = 0;
  int unsigned   stall_pct = 0;
  int unsigned   mismatch_count = 0;
  int unsigned   phase_items = 0;
  logic          byte_taken = 1'b0;

  focuser_command_frame_parser_core uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'h20 : c;
  endfunction

  // valid flag in bit 4, digit value below
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, c[3:0]};
    if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) return {1'b1, c[3:0] + 4'd9};
    return 5'd0;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // last table entry that matches wins
  function automatic logic [CODE_W-1:0] lookup_command(input int unsigned len);
    logic [CODE_W-1:0] code;
    logic [15:0]       name;
    logic              one_char;
    code = '0;
    if (len == 0) return code;
    for (int i = 0; i < CMD_COUNT; i++) begin
      name     = CMD_NAMES[16*(CMD_COUNT-1-i) +: 16];
      one_char = name[7:0] == " ";
      if (one_char == (len >= 2)) continue;
      if (to_upper(frame_mem[0]) != name[15:8]) continue;
      if (len >= 2 && to_upper(frame_mem[1]) != name[7:0]) continue;
      code = CODE_W'(i);
    end
    return code;
  endfunction

  // hex argument after the command characters, wraps at 16 bits
  function automatic logic [ARG_W-1:0] parse_hex_argument(input int unsigned len);
    int unsigned      p;
    logic             neg;
    logic [ARG_W-1:0] acc;
    logic [4:0]       d;
    p   = 2;
    neg = 1'b0;
    acc = '0;
    while (p < len && is_blank(frame_mem[p])) p++;
    if (p < len && (frame_mem[p] == CH_PLUS || frame_mem[p] == CH_MINUS)) begin
      neg = frame_mem[p] == CH_MINUS;
      p++;
    end
    // prefix only counts with a digit behind it
    d = (p + 2 < len) ? hex_digit(frame_mem[p+2]) : 5'd0;
    if (d[4] && frame_mem[p] == CH_ZERO &&
        (frame_mem[p+1] == CH_X_LO || frame_mem[p+1] == CH_X_UP))
      p += 2;
    while (p < len) begin
      d = hex_digit(frame_mem[p]);
      if (!d[4]) break;
      acc = {acc[ARG_W-5:0], d[3:0]};
      p++;
    end
    if (neg) acc = -acc;
    return acc;
  endfunction

  task automatic absorb_rx_byte(input logic [7:0] c);
    frame_result_t r;
    int unsigned   len;
    if (c == FRAME_END) begin
      len       = (frame_len > MEM_DEPTH - 1) ? MEM_DEPTH - 1 : frame_len;
      r.code    = lookup_command(len);
      r.has_arg = len > 2;
      r.arg     = (len > 2) ? parse_hex_argument(len) : '0;
      expected_frames.push_back(r);
      frame_len = 0;
    end else if (c == FRAME_START) begin
      frame_len = 0;
    end else begin
      // a full buffer keeps overwriting its last slot
      frame_mem[frame_len] = c;
      frame_len++;
      if (frame_len >= MEM_DEPTH) frame_len = MEM_DEPTH - 1;
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic push_byte(input logic [7:0] c);
    pending_bytes.push_back(c);
    phase_items++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == FRAME_END || c == FRAME_START);
    return c;
  endfunction

  function automatic logic [7:0] mixed_case(input logic [7:0] c);
    return (c >= "A" && c <= "Z" && $urandom_range(1)) ? c + 8'h20 : c;
  endfunction

  function automatic logic [7:0] hex_char();
    logic [3:0] v;
    v = 4'($urandom_range(15));
    if (v < 10) return "0" + v;
    return mixed_case("A" + v - 8'd10);
  endfunction

  task automatic push_argument();
    int unsigned n;
    n = $urandom_range(2);
    repeat (n) push_byte($urandom_range(1) ? CH_SPACE : 8'($urandom_range(9, 13)));
    case ($urandom_range(3))
      0: push_byte(CH_PLUS);
      1: push_byte(CH_MINUS);
      default: ;
    endcase
    if ($urandom_range(2) == 0) begin
      push_byte(CH_ZERO);
      push_byte($urandom_range(1) ? CH_X_LO : CH_X_UP);
    end
    n = $urandom_range(6);
    repeat (n) push_byte(hex_char());
    if ($urandom_range(4) == 0) push_byte(plain_byte());
  endtask

  task automatic queue_random_frame();
    int unsigned kind;
    int unsigned n;
    int unsigned idx;
    logic [15:0] name;
    kind = $urandom_range(99);
    if (kind < 8) begin
      // line noise, framing characters included
      n = $urandom_range(1, 6);
      repeat (n) push_byte(8'($urandom_range(255)));
    end else if (kind < 14) begin
      // long frame, often longer than the buffer
      push_byte(FRAME_START);
      n = $urandom_range(28, 45);
      repeat (n) push_byte(plain_byte());
      push_byte(FRAME_END);
    end else begin
      if ($urandom_range(3) != 0) push_byte(FRAME_START);
      kind = $urandom_range(99);
      if (kind < 75) begin
        idx  = $urandom_range(CMD_COUNT - 1);
        name = CMD_NAMES[16*(CMD_COUNT-1-idx) +: 16];
        push_byte(mixed_case(name[15:8]));
        if (name[7:0] != " ") push_byte(mixed_case(name[7:0]));
      end else if (kind < 88) begin
        push_byte(mixed_case(8'($urandom_range("A", "Z"))));
        push_byte(mixed_case(8'($urandom_range("A", "Z"))));
      end else begin
        n = $urandom_range(2);
        repeat (n) push_byte(plain_byte());
      end
      if ($urandom_range(3) != 0) push_argument();
      push_byte(FRAME_END);
    end
  endtask

  task automatic wait_idle();
    while (pending_bytes.size() != 0 || s_axis_tvalid || expected_frames.size() != 0)
      @(posedge clk);
  endtask

  // ---------------------------------------------------------------- driver

  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      // hold an item until it is taken
      if (!s_axis_tvalid || byte_taken) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_bytes.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= $urandom_range(99) >= stall_pct;
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic report_mismatch(input string field, input int exp_v, input int act_v);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch at %0t: %s expected %0h got %0h", $realtime, field, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    frame_result_t exp_r;
    byte_taken <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_frames.size() == 0) begin
        report_mismatch("unexpected item", 0, int'(m_axis_tdata));
      end else begin
        exp_r = expected_frames.pop_front();
        if (m_axis_tdata[CODE_W-1:0] != exp_r.code)
          report_mismatch("command_code", int'(exp_r.code),
                          int'(m_axis_tdata[CODE_W-1:0]));
        if (m_axis_tdata[CODE_W] != exp_r.has_arg)
          report_mismatch("has_argument", int'(exp_r.has_arg),
                          int'(m_axis_tdata[CODE_W]));
        if (m_axis_tdata[CODE_W+1 +: ARG_W] != exp_r.arg)
          report_mismatch("argument", int'(exp_r.arg),
                          int'(m_axis_tdata[CODE_W+1 +: ARG_W]));
        if (m_axis_tdata[OUT_TDATA_W-1] != 1'b0)
          report_mismatch("pad bit", 0, int'(m_axis_tdata[OUT_TDATA_W-1]));
      end
    end
    if (!rst && s_axis_tvalid && s_axis_tready) absorb_rx_byte(s_axis_tdata);
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed frames: empty, one-character commands, mixed case, restart,
    // blanks, sign and prefix, byte extremes
    push_text("#");
    push_text("+#");
    push_text("-#");
    push_text("fg#");
    push_text("x:Sp -0xfF#");
    push_text("Mr\t+0x#");
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(FRAME_END);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 84; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 84; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      if (ph != 0) phase_items = 0;
      while (phase_items < PHASE_ITEMS) queue_random_frame();
      wait_idle();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
